/* rtl/gtb_pkg.sv */
// Shared types, constants and helpers of the 2bpp glyph text blitter.
package gtb_pkg;

    // Defaults of the top level parameters (FONT_BYTES must be a power of two)
    localparam int FONT_BYTES_DEF      = 4096;
    localparam int MAX_GLYPH_ROWS_DEF  = 32;
    localparam int MAX_GLYPH_WIDTH_DEF = 32;

    // Field widths fixed by the interface
    localparam int KIND_W   = 2;
    localparam int FADDR_W  = 12;
    localparam int COORD_W  = 16;
    localparam int PIX_W    = 64;
    localparam int PCOUNT_W = 6;
    localparam int ARG_W    = 32;

    // Row byte walk: up to 8 bytes of four pixels each
    localparam int BYTE_CNT_W = 4;
    localparam int LANE_W     = 3;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Request kinds on the input channel
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PEN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAW = 2'd2;

    // Font header locations
    localparam int HDR_FIRST  = 2;
    localparam int HDR_LAST   = 3;
    localparam int OFFS_BASE  = 4;
    localparam int GLYPH_HDR  = 4;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_PEN,
        OP_DRAW
    } t_cmd_op;

    // Queued command: load {addr, byte}, pen {y, x}, draw {code}
    typedef struct packed {
        t_cmd_op           op;
        logic [ARG_W-1:0]  arg;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HDR0,
        S_HDR1,
        S_HDR2,
        S_OFF0,
        S_OFF1,
        S_GH0,
        S_GH1,
        S_GH2,
        S_GH3,
        S_ROW
    } t_state;

    // Keep the low 2*width bits of a row of 2-bit pixels
    function automatic logic [PIX_W-1:0] pix_mask(input logic [PCOUNT_W-1:0] width);
        logic [PIX_W-1:0] m;
        m = '0;
        for (int k = 0; k < PIX_W / 2; k++) begin
            if (PCOUNT_W'(k) < width) begin
                m[2*k +: 2] = 2'b11;
            end
        end
        return m;
    endfunction

endpackage

/* rtl/gtb_front.sv */
// Front end: accepts requests, drops those that cause nothing, packs commands.
module gtb_front (
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [gtb_pkg::KIND_W-1:0]    i_kind,
    input  logic [gtb_pkg::FADDR_W-1:0]   i_font_addr,
    input  logic [7:0]                    i_font_byte,
    input  logic [gtb_pkg::COORD_W-1:0]   i_pen_x,
    input  logic [gtb_pkg::COORD_W-1:0]   i_pen_y,
    input  logic [7:0]                    i_char_code,
    input  logic                          i_full,
    output logic                          o_push,
    output gtb_pkg::t_cmd                 o_cmd
);
    import gtb_pkg::*;

    logic keep;

    assign o_ready = !i_full;

    // Classify: unused kind and high codes are accepted and dropped
    always_comb begin
        keep      = 1'b0;
        o_cmd.op  = OP_LOAD;
        o_cmd.arg = '0;
        case (i_kind)
            KIND_LOAD: begin
                keep      = 1'b1;
                o_cmd.op  = OP_LOAD;
                o_cmd.arg = ARG_W'({i_font_addr, i_font_byte});
            end
            KIND_PEN: begin
                keep      = 1'b1;
                o_cmd.op  = OP_PEN;
                o_cmd.arg = {i_pen_y, i_pen_x};
            end
            KIND_DRAW: begin
                keep      = !i_char_code[7];
                o_cmd.op  = OP_DRAW;
                o_cmd.arg = ARG_W'(i_char_code[6:0]);
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = i_valid && o_ready && keep;

endmodule

/* rtl/gtb_queue.sv */
// Short command queue between the front end and the drawing engine.
module gtb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gtb_pkg::t_cmd  i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output gtb_pkg::t_cmd  o_head,
    input  logic           i_pop
);
    import gtb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* rtl/gtb_back.sv */
// Drawing engine: font memory, pen, glyph walk and the row result register.
module gtb_back #(
    parameter int FONT_BYTES      = gtb_pkg::FONT_BYTES_DEF,
    parameter int MAX_GLYPH_ROWS  = gtb_pkg::MAX_GLYPH_ROWS_DEF,
    parameter int MAX_GLYPH_WIDTH = gtb_pkg::MAX_GLYPH_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  gtb_pkg::t_cmd                  i_q_head,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [gtb_pkg::COORD_W-1:0]    o_row_x,
    output logic [gtb_pkg::COORD_W-1:0]    o_row_y,
    output logic [gtb_pkg::PIX_W-1:0]      o_row_pixels,
    output logic [gtb_pkg::PCOUNT_W-1:0]   o_pixel_count,
    output logic                           o_last_row,
    output logic                           o_clipped
);
    import gtb_pkg::*;

    localparam int AW    = $clog2(FONT_BYTES);
    localparam int ROW_W = $clog2(MAX_GLYPH_ROWS + 1);

    // Font memory
    logic [7:0]    mem [FONT_BYTES];
    logic [7:0]    r_rdata;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    t_state r_state, n_state;

    logic [6:0]            r_code;
    logic [7:0]            r_first;
    logic [AW-1:0]         r_lidx;
    logic [7:0]            r_goff_lo;
    logic [AW-1:0]         r_goff;
    logic [7:0]            r_top;
    logic [7:0]            r_pw;
    logic [7:0]            r_bw;
    logic [ROW_W-1:0]      r_rows;
    logic [PCOUNT_W-1:0]   r_width;
    logic                  r_clip;
    logic [ROW_W-1:0]      r_row;
    logic [AW-1:0]         r_base;
    logic [BYTE_CNT_W-1:0] r_byte;
    logic [PIX_W-1:0]      r_pix;
    logic [COORD_W-1:0]    r_pen_x;
    logic [COORD_W-1:0]    r_pen_y;

    logic                  r_out_valid;
    logic [COORD_W-1:0]    r_out_x;
    logic [COORD_W-1:0]    r_out_y;
    logic [PIX_W-1:0]      r_out_pix;
    logic [PCOUNT_W-1:0]   r_out_cnt;
    logic                  r_out_last;
    logic                  r_out_clip;

    logic [7:0]            code_off;
    logic                  code_in_range;
    logic [AW-1:0]         lidx;
    logic [15:0]           goff;
    logic [7:0]            rows_raw;
    logic [BYTE_CNT_W-1:0] nbytes;
    logic [LANE_W-1:0]     lane;
    logic [PIX_W-1:0]      row_pix;
    logic                  row_done;
    logic                  out_free;
    logic                  emit;
    logic                  last;

    // Glyph lookup arithmetic
    assign code_off      = {1'b0, r_code} - r_first;
    assign code_in_range = ({1'b0, r_code} >= r_first) && ({1'b0, r_code} <= r_rdata);
    assign lidx          = AW'({code_off, 1'b0} + 9'(OFFS_BASE));
    assign goff          = {r_rdata, r_goff_lo};
    assign rows_raw      = (r_rdata > r_top) ? (r_rdata - r_top) : 8'd0;

    // Row byte walk: byte j holds pixels 4j..4j+3 in row order
    assign nbytes   = BYTE_CNT_W'((7'(r_width) + 7'd3) >> 2);
    assign lane     = LANE_W'(r_byte - 1'b1);
    assign row_done = (r_state == S_ROW) && (r_byte == nbytes);
    assign out_free = !r_out_valid || i_ready;
    assign emit     = row_done && out_free;
    assign last     = ((r_row + ROW_W'(1)) == r_rows);

    always_comb begin
        row_pix = r_pix;
        if (r_byte != '0) begin
            row_pix[8*lane +: 8] = r_rdata;
        end
        row_pix = row_pix & pix_mask(r_width);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && i_q_head.op == OP_DRAW) begin
                    n_state = S_HDR0;
                end
            end
            S_HDR0: n_state = S_HDR1;
            S_HDR1: n_state = S_HDR2;
            S_HDR2: n_state = code_in_range ? S_OFF0 : S_IDLE;
            S_OFF0: n_state = S_OFF1;
            S_OFF1: n_state = S_GH0;
            S_GH0:  n_state = S_GH1;
            S_GH1:  n_state = S_GH2;
            S_GH2:  n_state = S_GH3;
            S_GH3:  n_state = (r_rows == '0) ? S_IDLE : S_ROW;
            S_ROW: begin
                if (emit && last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory port and queue pop
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        mem_we  = 1'b0;
        o_q_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_q_pop = i_q_valid;
                mem_we  = i_q_valid && (i_q_head.op == OP_LOAD);
            end
            S_HDR0: begin
                rd_en   = 1'b1;
                rd_addr = AW'(HDR_FIRST);
            end
            S_HDR1: begin
                rd_en   = 1'b1;
                rd_addr = AW'(HDR_LAST);
            end
            S_HDR2: begin
                rd_en   = 1'b1;
                rd_addr = lidx;
            end
            S_OFF0: begin
                rd_en   = 1'b1;
                rd_addr = r_lidx + 1'b1;
            end
            S_OFF1: begin
                rd_en   = 1'b1;
                rd_addr = AW'(goff);
            end
            S_GH0: begin
                rd_en   = 1'b1;
                rd_addr = r_goff + AW'(1);
            end
            S_GH1: begin
                rd_en   = 1'b1;
                rd_addr = r_goff + AW'(2);
            end
            S_GH2: begin
                rd_en   = 1'b1;
                rd_addr = r_goff + AW'(3);
            end
            S_ROW: begin
                rd_en   = (r_byte < nbytes);
                rd_addr = r_base + AW'(r_byte);
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Write on load, read registered; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[AW'(i_q_head.arg[19:8])] <= i_q_head.arg[7:0];
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Pen position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x <= '0;
            r_pen_y <= '0;
        end else if (r_state == S_IDLE && i_q_valid && i_q_head.op == OP_PEN) begin
            r_pen_x <= i_q_head.arg[15:0];
            r_pen_y <= i_q_head.arg[31:16];
        end else if ((r_state == S_GH3 && r_rows == '0) || (emit && last)) begin
            r_pen_x <= r_pen_x + COORD_W'(r_pw) + 1'b1;
        end
    end

    // Glyph walk datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: r_code    <= i_q_head.arg[6:0];
            S_HDR1: r_first   <= r_rdata;
            S_HDR2: r_lidx    <= lidx;
            S_OFF0: r_goff_lo <= r_rdata;
            S_OFF1: r_goff    <= AW'(goff);
            S_GH0:  r_top     <= r_rdata;
            S_GH1: begin
                r_clip <= (rows_raw > 8'(MAX_GLYPH_ROWS));
                r_rows <= (rows_raw > 8'(MAX_GLYPH_ROWS)) ? ROW_W'(MAX_GLYPH_ROWS)
                                                          : ROW_W'(rows_raw);
            end
            S_GH2: begin
                r_pw <= r_rdata;
                if (r_rdata > 8'(MAX_GLYPH_WIDTH)) begin
                    r_width <= PCOUNT_W'(MAX_GLYPH_WIDTH);
                    r_clip  <= 1'b1;
                end else begin
                    r_width <= PCOUNT_W'(r_rdata);
                end
            end
            S_GH3: begin
                r_bw   <= r_rdata;
                r_base <= r_goff + AW'(GLYPH_HDR);
                r_row  <= '0;
                r_byte <= '0;
            end
            S_ROW: begin
                if (r_byte != '0) begin
                    r_pix[8*lane +: 8] <= r_rdata;
                end
                if (emit) begin
                    r_row  <= r_row + 1'b1;
                    r_base <= r_base + AW'(r_bw);
                    r_byte <= '0;
                end else if (r_byte < nbytes) begin
                    r_byte <= r_byte + 1'b1;
                end
            end
            default: begin
                r_code <= r_code;
            end
        endcase
    end

    // Row result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_x    <= r_pen_x;
            r_out_y    <= r_pen_y + COORD_W'(r_top) + COORD_W'(r_row);
            r_out_pix  <= row_pix;
            r_out_cnt  <= r_width;
            r_out_last <= last;
            r_out_clip <= r_clip;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_row_x       = r_out_x;
    assign o_row_y       = r_out_y;
    assign o_row_pixels  = r_out_pix;
    assign o_pixel_count = r_out_cnt;
    assign o_last_row    = r_out_last;
    assign o_clipped     = r_out_clip;

`ifndef SYNTH
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_cnt <= PCOUNT_W'(MAX_GLYPH_WIDTH)))
        else $error("pixel count above glyph width limit");

    a_pix_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_pix & ~pix_mask(r_out_cnt)) == '0))
        else $error("pixel bits set beyond pixel count");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW) |-> (r_row < r_rows))
        else $error("row index past glyph row count");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && last) |=> (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("final row did not end the character");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_q_pop)
        else $error("queue popped while a character is in progress");
`endif

endmodule

/* rtl/glyph_text_blitter_2bpp.sv */
// Top level of the 2bpp glyph text blitter: front end, command queue, drawing engine.
//
//  channel  direction  handshake            payload
//  request  in         i_valid / o_ready    i_kind, i_font_addr, i_font_byte,
//                                           i_pen_x, i_pen_y, i_char_code
//  row      out        o_valid / i_ready    o_row_x, o_row_y, o_row_pixels,
//                                           o_pixel_count, o_last_row, o_clipped
//
// Load and pen requests are taken by the engine while it is idle; dropped requests never reach it.
// A drawn character first walks the header, offset and glyph header lookup, then
// reads the row bytes of each emitted row: the single font memory port serves
// one byte read per cycle, and each lookup step waits on the previous read.
// Reset is synchronous, active low; it clears the pen, queue and result register.
// The two-entry queue accepts requests until it is full while the engine waits
// on a stalled row result.
module glyph_text_blitter_2bpp #(
    parameter int FONT_BYTES      = gtb_pkg::FONT_BYTES_DEF,
    parameter int MAX_GLYPH_ROWS  = gtb_pkg::MAX_GLYPH_ROWS_DEF,
    parameter int MAX_GLYPH_WIDTH = gtb_pkg::MAX_GLYPH_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [gtb_pkg::KIND_W-1:0]     i_kind,
    input  logic [gtb_pkg::FADDR_W-1:0]    i_font_addr,
    input  logic [7:0]                     i_font_byte,
    input  logic [gtb_pkg::COORD_W-1:0]    i_pen_x,
    input  logic [gtb_pkg::COORD_W-1:0]    i_pen_y,
    input  logic [7:0]                     i_char_code,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [gtb_pkg::COORD_W-1:0]    o_row_x,
    output logic [gtb_pkg::COORD_W-1:0]    o_row_y,
    output logic [gtb_pkg::PIX_W-1:0]      o_row_pixels,
    output logic [gtb_pkg::PCOUNT_W-1:0]   o_pixel_count,
    output logic                           o_last_row,
    output logic                           o_clipped
);
    import gtb_pkg::*;

    logic q_full;
    logic q_push;
    t_cmd q_in;
    logic q_valid;
    t_cmd q_head;
    logic q_pop;

    gtb_front u_front (
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_font_addr (i_font_addr),
        .i_font_byte (i_font_byte),
        .i_pen_x     (i_pen_x),
        .i_pen_y     (i_pen_y),
        .i_char_code (i_char_code),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_cmd       (q_in)
    );

    gtb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    gtb_back #(
        .FONT_BYTES      (FONT_BYTES),
        .MAX_GLYPH_ROWS  (MAX_GLYPH_ROWS),
        .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_head      (q_head),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_row_x       (o_row_x),
        .o_row_y       (o_row_y),
        .o_row_pixels  (o_row_pixels),
        .o_pixel_count (o_pixel_count),
        .o_last_row    (o_last_row),
        .o_clipped     (o_clipped)
    );

endmodule

/* sim/gtb_tb_pkg.sv */
// Request and row types, and the row scoreboard with its glyph predictor.
`timescale 1ns / 100ps
package gtb_tb_pkg;
    import gtb_pkg::*;

    // Kind value that the block drops without effect
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int PIX_PER_BYTE = 4;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FADDR_W-1:0] font_addr;
        logic [7:0]         font_byte;
        logic [COORD_W-1:0] pen_x;
        logic [COORD_W-1:0] pen_y;
        logic [7:0]         char_code;
    } t_blit_req;

    typedef struct packed {
        logic [COORD_W-1:0]  row_x;
        logic [COORD_W-1:0]  row_y;
        logic [PIX_W-1:0]    row_pixels;
        logic [PCOUNT_W-1:0] pixel_count;
        logic                last_row;
        logic                clipped;
    } t_glyph_row;

    class glyph_row_scoreboard;
        logic [7:0]         font_mem [FONT_BYTES_DEF];
        logic [COORD_W-1:0] pen_col;
        logic [COORD_W-1:0] pen_row;
        t_glyph_row         pending_rows [$];
        int                 mismatches;

        function new();
            pen_col    = '0;
            pen_row    = '0;
            mismatches = 0;
            foreach (font_mem[a]) font_mem[a] = '0;
        endfunction

        // Wrap every font address to the memory size
        function logic [7:0] font_byte_at(int unsigned addr);
            return font_mem[addr % FONT_BYTES_DEF];
        endfunction

        // Look up the glyph and queue one expected row per emitted glyph row
        function void render_glyph(logic [7:0] code);
            int unsigned first, last, slot, goff, top, bot, pw, bw, rows, width, base;
            logic [7:0]  data;
            logic        clip;
            t_glyph_row  row;
            if (code >= 8'd128) return;
            first = font_byte_at(HDR_FIRST);
            last  = font_byte_at(HDR_LAST);
            if (code < first || code > last) return;
            slot = OFFS_BASE + 2 * (code - first);
            goff = {font_byte_at(slot + 1), font_byte_at(slot)};
            top  = font_byte_at(goff);
            bot  = font_byte_at(goff + 1);
            pw   = font_byte_at(goff + 2);
            bw   = font_byte_at(goff + 3);
            rows = (bot > top) ? bot - top : 0;
            clip = 1'b0;
            if (rows > MAX_GLYPH_ROWS_DEF) begin
                rows = MAX_GLYPH_ROWS_DEF;
                clip = 1'b1;
            end
            width = pw;
            if (width > MAX_GLYPH_WIDTH_DEF) begin
                width = MAX_GLYPH_WIDTH_DEF;
                clip  = 1'b1;
            end
            for (int unsigned r = 0; r < rows; r++) begin
                // row stride at full width, no 8-bit wrap of bw * r
                base = goff + GLYPH_HDR + bw * r;
                row.row_pixels = '0;
                for (int unsigned k = 0; k < width; k++) begin
                    data = font_byte_at(base + k / PIX_PER_BYTE);
                    row.row_pixels[2*k +: 2] = data[2*(k % PIX_PER_BYTE) +: 2];
                end
                row.row_x       = pen_col;
                row.row_y       = COORD_W'(pen_row + top + r);
                row.pixel_count = PCOUNT_W'(width);
                row.last_row    = (r + 1 == rows);
                row.clipped     = clip;
                pending_rows.push_back(row);
            end
            // advance by the full glyph width even when clipped
            pen_col = COORD_W'(pen_col + pw + 1);
        endfunction

        // Update the model state with one accepted request
        function void note_request(t_blit_req req);
            case (req.kind)
                KIND_LOAD: font_mem[req.font_addr] = req.font_byte;
                KIND_PEN: begin
                    pen_col = req.pen_x;
                    pen_row = req.pen_y;
                end
                KIND_DRAW: render_glyph(req.char_code);
                default: ;
            endcase
        endfunction

        function void compare_field(string field, logic [PIX_W-1:0] want,
                                    logic [PIX_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        // Match one accepted row against the oldest expected row
        function void check_row(t_glyph_row got);
            t_glyph_row want;
            if (pending_rows.size() == 0) begin
                $error("row at x=0x%0h y=0x%0h arrived with no row expected",
                       got.row_x, got.row_y);
                mismatches++;
                return;
            end
            want = pending_rows.pop_front();
            compare_field("row_x", PIX_W'(want.row_x), PIX_W'(got.row_x));
            compare_field("row_y", PIX_W'(want.row_y), PIX_W'(got.row_y));
            compare_field("row_pixels", want.row_pixels, got.row_pixels);
            compare_field("pixel_count", PIX_W'(want.pixel_count), PIX_W'(got.pixel_count));
            compare_field("last_row", PIX_W'(want.last_row), PIX_W'(got.last_row));
            compare_field("clipped", PIX_W'(want.clipped), PIX_W'(got.clipped));
        endfunction

        function void report_leftovers();
            if (pending_rows.size() != 0) begin
                $error("%0d expected rows never arrived", pending_rows.size());
                mismatches++;
            end
        endfunction
    endclass

endpackage

/* sim/testbench.sv */
// Testbench top: drives font, pen and draw requests into the blitter and checks its rows.
`timescale 1ns / 100ps
module testbench;
    import gtb_pkg::*;
    import gtb_tb_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RANDOM_REQS    = 330;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int TIMEOUT_NS     = 8_000_000;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic [KIND_W-1:0]   i_kind        = '0;
    logic [FADDR_W-1:0]  i_font_addr   = '0;
    logic [7:0]          i_font_byte   = '0;
    logic [COORD_W-1:0]  i_pen_x       = '0;
    logic [COORD_W-1:0]  i_pen_y       = '0;
    logic [7:0]          i_char_code   = '0;
    logic                i_ready       = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [COORD_W-1:0]  o_row_x;
    logic [COORD_W-1:0]  o_row_y;
    logic [PIX_W-1:0]    o_row_pixels;
    logic [PCOUNT_W-1:0] o_pixel_count;
    logic                o_last_row;
    logic                o_clipped;

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    int unsigned reqs_sent    = 0;
    int unsigned rx_hold_left = 0;
    bit          rx_hold_req  = 1'b0;

    glyph_row_scoreboard sb = new();

    glyph_text_blitter_2bpp DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_font_addr   (i_font_addr),
        .i_font_byte   (i_font_byte),
        .i_pen_x       (i_pen_x),
        .i_pen_y       (i_pen_y),
        .i_char_code   (i_char_code),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_row_x       (o_row_x),
        .o_row_y       (o_row_y),
        .o_row_pixels  (o_row_pixels),
        .o_pixel_count (o_pixel_count),
        .o_last_row    (o_last_row),
        .o_clipped     (o_clipped)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Bound the run
    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    // Row side: check accepted rows, then pick ready for the next cycle
    always @(posedge i_clk) begin
        t_glyph_row got;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got.row_x       = o_row_x;
                got.row_y       = o_row_y;
                got.row_pixels  = o_row_pixels;
                got.pixel_count = o_pixel_count;
                got.last_row    = o_last_row;
                got.clipped     = o_clipped;
                sb.check_row(got);
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_ready <= 1'b0;
            end else if (rx_hold_req) begin
                rx_hold_req  = 1'b0;
                rx_hold_left = RX_HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic set_idling(int unsigned phase);
        case (phase)
            0: begin
                tx_idle_pct = 31;
                rx_idle_pct = 53;
            end
            1: begin
                tx_idle_pct = 53;
                rx_idle_pct = 31;
            end
            default: begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    endtask

    // Fill fields the kind does not use with noise
    function automatic t_blit_req random_req(logic [KIND_W-1:0] kind);
        t_blit_req req;
        req.kind      = kind;
        req.font_addr = FADDR_W'($urandom);
        req.font_byte = 8'($urandom);
        req.pen_x     = COORD_W'($urandom);
        req.pen_y     = COORD_W'($urandom);
        req.char_code = 8'($urandom);
        return req;
    endfunction

    // Offer one request, hold it until accepted, then tell the scoreboard
    task automatic send_req(input t_blit_req req);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= req.kind;
        i_font_addr <= req.font_addr;
        i_font_byte <= req.font_byte;
        i_pen_x     <= req.pen_x;
        i_pen_y     <= req.pen_y;
        i_char_code <= req.char_code;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(req);
        if (req.kind != KIND_UNUSED) reqs_sent++;
    endtask

    task automatic send_load(input int unsigned addr, input logic [7:0] data);
        t_blit_req req;
        req           = random_req(KIND_LOAD);
        req.font_addr = FADDR_W'(addr);
        req.font_byte = data;
        send_req(req);
    endtask

    task automatic send_pen(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        t_blit_req req;
        req       = random_req(KIND_PEN);
        req.pen_x = x;
        req.pen_y = y;
        send_req(req);
    endtask

    task automatic send_draw(input logic [7:0] code);
        t_blit_req req;
        req           = random_req(KIND_DRAW);
        req.char_code = code;
        send_req(req);
    endtask

    task automatic put_header(input logic [7:0] first, input logic [7:0] last);
        send_load(HDR_FIRST, first);
        send_load(HDR_LAST, last);
    endtask

    // Point a code at a glyph and write the glyph header; row bytes stay as they are
    task automatic put_glyph(input logic [7:0] code, input logic [15:0] goff,
                             input logic [7:0] top, input logic [7:0] bot,
                             input logic [7:0] pw, input logic [7:0] bw);
        int unsigned slot;
        slot = OFFS_BASE + 2 * (code - sb.font_mem[HDR_FIRST]);
        send_load(slot, goff[7:0]);
        send_load(slot + 1, goff[15:8]);
        send_load(goff, top);
        send_load(goff + 1, bot);
        send_load(goff + 2, pw);
        send_load(goff + 3, bw);
    endtask

    // Stop offering requests until every expected row is back and the engine is idle
    task automatic pause_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned first, last, lo, hi, sel, phase, base_count, done;
        int unsigned code, goff, top, rows, bot, pw, bw;
        bit          in_font;
        set_idling(0);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Write every font byte once so no lookup reads an unwritten entry
        for (int a = 0; a < FONT_BYTES_DEF; a++) send_load(a, 8'($urandom));

        // Directed font: ordinary, empty, clipped, zero width, wrapped and wide-stride glyphs
        put_header(8'h20, 8'h7E);
        put_glyph(8'h41, 16'h0400, 8'd2, 8'd10, 8'd7, 8'd2);
        put_glyph(8'h42, 16'h1440, 8'd0, 8'd32, 8'd32, 8'd8);
        put_glyph(8'h43, 16'h0480, 8'd5, 8'd5, 8'd9, 8'd3);
        put_glyph(8'h44, 16'h0490, 8'd9, 8'd3, 8'd4, 8'd1);
        put_glyph(8'h45, 16'h04A0, 8'd0, 8'd40, 8'd3, 8'd1);
        put_glyph(8'h46, 16'h04B0, 8'd1, 8'd4, 8'd200, 8'd50);
        put_glyph(8'h47, 16'h04C0, 8'd0, 8'd3, 8'd0, 8'd0);
        put_glyph(8'h48, 16'h0FFE, 8'd0, 8'd20, 8'd16, 8'd20);
        put_glyph(8'h20, 16'h04D0, 8'd250, 8'd255, 8'd255, 8'd255);
        put_glyph(8'h7E, 16'h8FF0, 8'd0, 8'd1, 8'd1, 8'd1);

        // Hold off the row side so the queue fills and back-pressures requests
        rx_hold_req = 1'b1;
        send_pen(16'h0000, 16'h0000);
        for (int c = 8'h41; c <= 8'h48; c++) send_draw(8'(c));
        send_draw(8'h20);
        send_draw(8'h7E);
        send_pen(16'hFFFF, 16'hFFFF);
        send_draw(8'h41);
        send_pen(16'hFFF8, 16'h1234);
        send_draw(8'h46);
        send_draw(8'h41);
        send_draw(8'h1F);
        send_draw(8'h7F);
        send_draw(8'h80);
        send_draw(8'hFF);
        send_req(random_req(KIND_UNUSED));
        send_draw(8'h47);

        // Random part: mostly well-formed glyphs and draws, with noise mixed in
        base_count = reqs_sent;
        phase      = 0;
        done       = 0;
        while (done < RANDOM_REQS) begin
            if (done * 3 / RANDOM_REQS != phase) begin
                phase = done * 3 / RANDOM_REQS;
                pause_until_drained();
                set_idling(phase);
                if (phase == 2) rx_hold_req = 1'b1;
            end
            first   = sb.font_mem[HDR_FIRST];
            last    = sb.font_mem[HDR_LAST];
            lo      = first;
            hi      = (last > 127) ? 127 : last;
            in_font = (lo <= hi);
            sel     = $urandom_range(99);
            if (sel < 6 || !in_font) begin
                // new code range, now and then a broken one
                if ($urandom_range(99) < 85) begin
                    first = $urandom_range(8'h60);
                    last  = first + $urandom_range(40);
                end else begin
                    first = $urandom_range(255);
                    last  = $urandom_range(255);
                end
                put_header(8'(first), 8'(last));
            end else if (sel < 24) begin
                code = $urandom_range(hi, lo);
                goff = ($urandom_range(9) == 0) ? $urandom_range(16'hFFFF)
                                                : $urandom_range(12'hFFF, 12'h100);
                top  = $urandom_range(40);
                rows = ($urandom_range(9) == 0) ? $urandom_range(40, 30) : $urandom_range(12);
                bot  = ($urandom_range(19) == 0) ? top / 2 : top + rows;
                pw   = ($urandom_range(9) == 0) ? $urandom_range(255, 33) : $urandom_range(32);
                bw   = ($urandom_range(7) == 0) ? $urandom_range(255) : (pw + 3) / 4;
                put_glyph(8'(code), 16'(goff), 8'(top), 8'(bot), 8'(pw), 8'(bw));
            end else if (sel < 34) begin
                if ($urandom_range(9) < 7) begin
                    send_pen(COORD_W'($urandom_range(16'h200)), COORD_W'($urandom_range(16'h200)));
                end else begin
                    send_pen(COORD_W'($urandom), COORD_W'($urandom));
                end
            end else if (sel < 40) begin
                send_load($urandom_range(FONT_BYTES_DEF - 1), 8'($urandom));
            end else if (sel < 43) begin
                send_req(random_req(KIND_UNUSED));
            end else begin
                if ($urandom_range(9) < 8) begin
                    send_draw(8'($urandom_range(hi, lo)));
                end else begin
                    send_draw(8'($urandom_range(255)));
                end
            end
            done = reqs_sent - base_count;
        end

        // Wait out the last rows, then report
        pause_until_drained();
        sb.report_leftovers();
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
